>>> design/atpr_pkg.sv
// Package for the accelerometer tilt block: angle table and shared constants.
// No dependencies.
`timescale 1ns / 1ps
package atpr_pkg;
  localparam int ATAN_STEPS = 24;
  localparam int ZW = 24;
  localparam int AW = 15;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 24'sd2949120;
      1: t = 24'sd1740967;
      2: t = 24'sd919879;
      3: t = 24'sd466945;
      4: t = 24'sd234379;
      5: t = 24'sd117304;
      6: t = 24'sd58666;
      7: t = 24'sd29335;
      8: t = 24'sd14668;
      9: t = 24'sd7334;
      10: t = 24'sd3667;
      11: t = 24'sd1833;
      12: t = 24'sd917;
      13: t = 24'sd458;
      14: t = 24'sd229;
      15: t = 24'sd115;
      16: t = 24'sd57;
      17: t = 24'sd29;
      18: t = 24'sd14;
      19: t = 24'sd7;
      20: t = 24'sd4;
      21: t = 24'sd2;
      22: t = 24'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage

>>> design/atpr_sqrt_cell.sv
// One restoring square root step, one result bit per cell.
// No dependencies.
`timescale 1ns / 1ps
module atpr_sqrt_cell #(
  parameter int RW = 50,
  parameter int QW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] root_in,
  input  logic [2*QW-1:0] rad_in,
  output logic [RW-1:0] rem_out,
  output logic [QW-1:0] root_out,
  output logic [2*QW-1:0] rad_out
);
  logic [RW-1:0] r2;
  logic [RW-1:0] trial;
  always_comb begin
    r2 = {rem_in[RW-3:0], rad_in[2*QW-1 -: 2]};
    trial = RW'({root_in, 2'b01});
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= {rad_in[2*QW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_out <= r2 - trial;
        root_out <= {root_in[QW-2:0], 1'b1};
      end else begin
        rem_out <= r2;
        root_out <= {root_in[QW-2:0], 1'b0};
      end
    end
  end
endmodule

>>> design/atpr_cordic_cell.sv
// One CORDIC vectoring rotation with its table angle.
// Depends on atpr_pkg.
`timescale 1ns / 1ps
module atpr_cordic_cell #(
  parameter int W = 34,
  parameter int I = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic signed [atpr_pkg::ZW-1:0] z_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic signed [atpr_pkg::ZW-1:0] z_out
);
  import atpr_pkg::*;
  localparam logic signed [ZW-1:0] T = atan_q16(I);
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[W-1]) begin
        x_out <= x_in + (y_in >>> I);
        y_out <= y_in - (x_in >>> I);
        z_out <= z_in + T;
      end else begin
        x_out <= x_in - (y_in >>> I);
        y_out <= y_in + (x_in >>> I);
        z_out <= z_in - T;
      end
    end
  end
endmodule

>>> design/atpr_tilt.sv
// One tilt angle: squares, square root cells, CORDIC cells, rounding.
// Depends on atpr_pkg, atpr_sqrt_cell, atpr_cordic_cell.
`timescale 1ns / 1ps
module atpr_tilt #(
  parameter int SAMPLE_BITS = 13,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic clk,
  input  logic en,
  input  logic signed [SAMPLE_BITS-1:0] num,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  output logic signed [atpr_pkg::AW-1:0] angle
);
  import atpr_pkg::*;
  localparam int SQW = 2 * SAMPLE_BITS;
  localparam int QW = SAMPLE_BITS + 17;
  localparam int RW = QW + 2;
  localparam int W = SAMPLE_BITS + 21;
  localparam int NIT = (ANGLE_ITERATIONS < ATAN_STEPS) ? ANGLE_ITERATIONS : ATAN_STEPS;
  localparam int LAT = 1 + QW + NIT;

  logic [SQW-1:0] sq;
  logic signed [SAMPLE_BITS-1:0] num0;
  logic [RW-1:0] rem [0:QW];
  logic [QW-1:0] root [0:QW];
  logic [2*QW-1:0] rad [0:QW];
  logic signed [SAMPLE_BITS-1:0] nd [0:QW];
  logic zd [0:LAT];
  logic signed [SAMPLE_BITS-1:0] nz [0:LAT];
  logic signed [W-1:0] xs [0:NIT];
  logic signed [W-1:0] ys [0:NIT];
  logic signed [ZW-1:0] zs [0:NIT];

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= $unsigned(SQW'(a) * SQW'(a)) + $unsigned(SQW'(b) * SQW'(b));
      num0 <= num;
    end
  end
  assign rem[0] = '0;
  assign root[0] = '0;
  assign rad[0] = (2*QW)'({sq, 32'd0});
  assign nd[0] = num0;
  for (genvar k = 0; k < QW; k++) begin : g_sq
    atpr_sqrt_cell #(.RW(RW), .QW(QW)) u_c (
      .clk(clk), .en(en), .rem_in(rem[k]), .root_in(root[k]), .rad_in(rad[k]),
      .rem_out(rem[k+1]), .root_out(root[k+1]), .rad_out(rad[k+1]));
    always_ff @(posedge clk) begin
      if (en) nd[k+1] <= nd[k];
    end
  end
  assign xs[0] = W'($signed({1'b0, root[QW]}));
  assign ys[0] = W'(nd[QW]) <<< 16;
  assign zs[0] = '0;
  for (genvar i = 0; i < NIT; i++) begin : g_cd
    atpr_cordic_cell #(.W(W), .I(i)) u_c (
      .clk(clk), .en(en), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1]));
  end
  // zero-denominator bypass travels alongside
  assign zd[0] = (a == '0) && (b == '0);
  assign nz[0] = num;
  for (genvar j = 0; j < LAT; j++) begin : g_d
    always_ff @(posedge clk) begin
      if (en) begin
        zd[j+1] <= zd[j];
        nz[j+1] <= nz[j];
      end
    end
  end

  logic [ZW-1:0] mag;
  logic [ZW+7:0] scaled;
  logic [16:0] h;
  logic [16:0] hc;
  always_comb begin
    mag = zs[NIT][ZW-1] ? ZW'(-zs[NIT]) : ZW'(zs[NIT]);
    scaled = (ZW+8)'(mag) * (ZW+8)'(100) + (ZW+8)'(32768);
    h = 17'(scaled >> 16);
    hc = (h > 17'd9000) ? 17'd9000 : h;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (zd[LAT]) begin
        angle <= nz[LAT][SAMPLE_BITS-1] ? -AW'(9000) : ((nz[LAT] == '0) ? '0 : AW'(9000));
      end else begin
        angle <= zs[NIT][ZW-1] ? -AW'(hc) : AW'(hc);
      end
    end
  end
endmodule

>>> design/accel_tilt_pitch_roll.sv
// Top level: pitch and roll from one three-axis sample, fully pipelined.
// Depends on atpr_pkg, atpr_tilt.
//   channel | signals                         | direction
//   in      | valid, ready, accel_x/y/z       | request in
//   out     | out_valid, out_ready, angles    | request out
// One request per cycle while the output is not stalled. Stages in order:
// squaring, one square-root cell per root bit, one CORDIC cell per
// iteration, rounding. The whole pipe advances when the output slot is
// free or being taken; a stall at the output holds every stage.
// Reset clears only the valid bits.
`timescale 1ns / 1ps
module accel_tilt_pitch_roll #(
  parameter int SAMPLE_BITS = 13,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [atpr_pkg::AW-1:0] pitch_angle,
  output logic signed [atpr_pkg::AW-1:0] roll_angle
);
  import atpr_pkg::*;
  localparam int NIT = (ANGLE_ITERATIONS < ATAN_STEPS) ? ANGLE_ITERATIONS : ATAN_STEPS;
  localparam int LAT = 2 + SAMPLE_BITS + 17 + NIT;
  logic [LAT-1:0] vld;
  logic en;
  assign en = !vld[LAT-1] || out_ready;
  assign ready = en;
  assign out_valid = vld[LAT-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], valid};
    end
  end
  atpr_tilt #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_pitch (
    .clk(clk), .en(en), .num(accel_x), .a(accel_y), .b(accel_z), .angle(pitch_angle));
  atpr_tilt #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_roll (
    .clk(clk), .en(en), .num(accel_y), .a(accel_x), .b(accel_z), .angle(roll_angle));
endmodule
